// ===== rtl/core/linear_probe_hash_table_assert.svh =====
// Assertion macros for the linear probing hash table.
// Used by the top level only; no other dependencies.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Checks that a condition implies another at the same edge.
`define LPHT_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("implication failed");

// Checks that a condition implies another at the next edge.
`define LPHT_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/core/lpht_pkg.sv =====
// Package for the linear probing hash table: widths, codes and reset values.
// No dependencies.
`timescale 1ns / 1ps
package lpht_pkg;
    localparam int MAX_SLOTS_DEF = 1024;
    localparam int KEY_BITS_DEF  = 29;
    localparam int CFG_W         = 11;
    localparam int SZ_W          = 11;
    localparam int PCT_W         = 7;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_LIVE  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_NOTFOUND = 2'd1;
    localparam logic [1:0] RES_FULL     = 2'd2;

    localparam logic [1:0] CFG_MIN_SIZE = 2'd0;
    localparam logic [1:0] CFG_SHRINK   = 2'd1;
    localparam logic [1:0] CFG_GROW     = 2'd2;

    localparam logic [10:0] MIN_SIZE_RST = 11'd16;
    localparam logic [6:0]  SHRINK_RST   = 7'd25;
    localparam logic [6:0]  GROW_RST     = 7'd75;
endpackage

// ===== rtl/core/linear_probe_hash_table.sv =====
// Linear probing hash table with tombstones, growth and shrinking by rehash.
// Depends on lpht_pkg and linear_probe_hash_table_assert.svh.
//
//   channel   dir  payload (low bit first)                          accepted when
//   s_axis    in   tdata: func[1:0], key[KEY_BITS+1:2]             s_tvalid & s_tready
//   m_axis    out  tdata: status, slot, distance, max_distance     m_tvalid & m_tready
//   cfg       in   cfg_index, cfg_data                              cfg_we
//
// One transaction at a time. The modulo (key mod size) is a restoring divider
// working one key bit at a time; each probe then goes through the single
// slot memory port (address, registered read). Without a rehash an item passes
// the grow check, the divider, the probe walk, for a delete a shrink check, and
// the output state. A rehash clears a scratch table (one slot a cycle), scans the
// old table slot by slot, moves each live slot with its own modulo and probe
// walk, then copies all MAX_SLOTS slots back.
// After reset a clearing pass over all MAX_SLOTS slots empties the status memories
// before s_tready rises.
// The result is held in an output register; a stall there only delays the next item.
`timescale 1ns / 1ps
`include "linear_probe_hash_table_assert.svh"
module linear_probe_hash_table #(
    parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF,
    parameter int KEY_BITS  = lpht_pkg::KEY_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // func[1:0], key[KEY_BITS+1:2], zero fill
    input  logic [((KEY_BITS+2+7)/8)*8-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // status[1:0], slot[11:2], distance[21:12], max_distance[31:22]
    output logic [31:0]                            m_tdata,
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_index,
    input  logic [lpht_pkg::CFG_W-1:0]             cfg_data
);
    import lpht_pkg::*;

    localparam int AW   = $clog2(MAX_SLOTS);
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int LW   = (CW > SZ_W) ? CW : SZ_W;
    localparam int PW   = LW + 7;
    localparam int KCW  = $clog2(KEY_BITS + 1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_GROWCHK, S_DIV, S_PRB_A, S_PRB_R, S_DEL_SHR,
        S_RH_CLR, S_RH_SCAN_A, S_RH_SCAN_R, S_RH_DIV, S_RH_PA, S_RH_PR,
        S_RH_COPY_A, S_RH_COPY_W, S_OUT
    } state_t;

    typedef enum logic [1:0] { R_INS, R_DEL } rh_src_t;

    // Memories
    logic [KEY_BITS-1:0] key_mem [MAX_SLOTS];
    logic [1:0]          st_mem  [MAX_SLOTS];
    logic [KEY_BITS-1:0] rkey_mem[MAX_SLOTS];
    logic [1:0]          rst_mem [MAX_SLOTS];

    state_t              state_reg;
    rh_src_t             src_reg;
    logic [SZ_W-1:0]     min_size_reg;
    logic [PCT_W-1:0]    shrink_reg, grow_reg;
    logic [LW-1:0]       size_reg, new_size_reg, occ_reg, live_reg;
    logic [9:0]          maxd_reg;
    logic [1:0]          func_reg;
    logic [KEY_BITS-1:0] key_reg, mkey_reg;
    logic [LW-1:0]       rem_reg, div_m_reg;
    logic [KCW-1:0]      bit_reg;
    logic [LW-1:0]       home_reg, pos_reg, dist_reg, scan_reg;
    logic [KEY_BITS-1:0] rd_key_reg, rrd_key_reg;
    logic [1:0]          rd_st_reg, rrd_st_reg;
    logic [1:0]          res_st_reg;
    logic [9:0]          res_slot_reg, res_dist_reg;
    logic                out_v_reg;

    // Effective minimum size
    logic [LW-1:0] eff_min;
    always_comb begin
        if (min_size_reg == '0) eff_min = LW'(1);
        else if (LW'(min_size_reg) > LW'(MAX_SLOTS)) eff_min = LW'(MAX_SLOTS);
        else eff_min = LW'(min_size_reg);
    end

    // Shared divider step: one quotient bit per cycle
    logic [LW:0] div_try;
    assign div_try = {rem_reg, mkey_reg[KEY_BITS-1]} - {1'b0, div_m_reg};

    logic [LW-1:0] pos_inc;
    assign pos_inc = (pos_reg + LW'(1) >= div_m_reg) ? '0 : pos_reg + LW'(1);

    logic [PW-1:0] occ100, grow_prod, live100, shr_prod;
    assign occ100    = PW'(occ_reg) * PW'(100);
    assign grow_prod = PW'(grow_reg) * PW'(size_reg);
    assign live100   = PW'(live_reg) * PW'(100);
    assign shr_prod  = PW'(shrink_reg) * PW'(size_reg);

    logic [LW-1:0] half_size;
    assign half_size = ((size_reg >> 1) < eff_min) ? eff_min : (size_reg >> 1);

    logic [LW-1:0] dbl_size;
    assign dbl_size = (size_reg >= LW'(MAX_SLOTS / 2)) ? LW'(MAX_SLOTS) : (size_reg << 1);

    assign s_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {maxd_reg, res_dist_reg, res_slot_reg, res_st_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            scan_reg     <= '0;
            min_size_reg <= MIN_SIZE_RST;
            shrink_reg   <= SHRINK_RST;
            grow_reg     <= GROW_RST;
            size_reg     <= LW'(MIN_SIZE_RST);
            occ_reg      <= '0;
            live_reg     <= '0;
            maxd_reg     <= '0;
            out_v_reg    <= 1'b0;
            src_reg      <= R_INS;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MIN_SIZE: min_size_reg <= cfg_data[SZ_W-1:0];
                    CFG_SHRINK:   shrink_reg   <= cfg_data[PCT_W-1:0];
                    CFG_GROW:     grow_reg     <= cfg_data[PCT_W-1:0];
                    default: ;
                endcase
            end
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: begin
                    st_mem[scan_reg[AW-1:0]]  <= ST_EMPTY;
                    rst_mem[scan_reg[AW-1:0]] <= ST_EMPTY;
                    if (scan_reg == LW'(MAX_SLOTS - 1)) begin
                        scan_reg  <= '0;
                        state_reg <= S_IDLE;
                    end else scan_reg <= scan_reg + LW'(1);
                end
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        func_reg  <= s_tdata[1:0];
                        key_reg   <= s_tdata[KEY_BITS+1:2];
                        if (size_reg == '0 || size_reg > LW'(MAX_SLOTS)) size_reg <= eff_min;
                        state_reg <= S_GROWCHK;
                    end
                end
                S_GROWCHK: begin
                    res_st_reg   <= RES_NOTFOUND;
                    res_slot_reg <= '0;
                    res_dist_reg <= '0;
                    if (func_reg == FUNC_INSERT && occ100 > grow_prod) begin
                        new_size_reg <= dbl_size;
                        src_reg      <= R_INS;
                        scan_reg     <= '0;
                        state_reg    <= S_RH_CLR;
                    end else if (func_reg == FUNC_INSERT || func_reg == FUNC_DELETE
                                 || func_reg == FUNC_LOOKUP) begin
                        mkey_reg  <= key_reg;
                        rem_reg   <= '0;
                        div_m_reg <= size_reg;
                        bit_reg   <= KCW'(KEY_BITS);
                        if (func_reg == FUNC_INSERT) res_st_reg <= RES_FULL;
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_DIV: begin
                    rem_reg  <= div_try[LW] ? {rem_reg[LW-2:0], mkey_reg[KEY_BITS-1]}
                                            : div_try[LW-1:0];
                    mkey_reg <= mkey_reg << 1;
                    bit_reg  <= bit_reg - KCW'(1);
                    if (bit_reg == KCW'(1)) state_reg <= S_PRB_A;
                    pos_reg  <= '0;
                    dist_reg <= '0;
                end
                S_PRB_A: begin
                    if (dist_reg == '0 && bit_reg == '0 && pos_reg == '0) pos_reg <= rem_reg;
                    bit_reg <= KCW'(1);
                    rd_st_reg  <= st_mem[(dist_reg == '0 && bit_reg == '0)
                                         ? rem_reg[AW-1:0] : pos_reg[AW-1:0]];
                    rd_key_reg <= key_mem[(dist_reg == '0 && bit_reg == '0)
                                          ? rem_reg[AW-1:0] : pos_reg[AW-1:0]];
                    state_reg  <= S_PRB_R;
                end
                S_PRB_R: begin
                    if (func_reg == FUNC_INSERT) begin
                        if (rd_st_reg == ST_EMPTY) begin
                            st_mem[pos_reg[AW-1:0]]  <= ST_LIVE;
                            key_mem[pos_reg[AW-1:0]] <= key_reg;
                            occ_reg      <= occ_reg + LW'(1);
                            live_reg     <= live_reg + LW'(1);
                            res_st_reg   <= RES_OK;
                            res_slot_reg <= 10'(pos_reg);
                            res_dist_reg <= 10'(dist_reg);
                            state_reg    <= S_OUT;
                        end else if (dist_reg + LW'(1) >= size_reg) state_reg <= S_OUT;
                        else begin
                            pos_reg <= pos_inc; dist_reg <= dist_reg + LW'(1);
                            state_reg <= S_PRB_A;
                        end
                    end else begin
                        if (rd_st_reg == ST_LIVE && rd_key_reg == key_reg) begin
                            res_st_reg   <= RES_OK;
                            res_slot_reg <= 10'(pos_reg);
                            res_dist_reg <= 10'(dist_reg);
                            if (func_reg == FUNC_DELETE) begin
                                st_mem[pos_reg[AW-1:0]] <= ST_TOMB;
                                if (live_reg != '0) live_reg <= live_reg - LW'(1);
                                state_reg <= S_DEL_SHR;
                            end else begin
                                if (10'(dist_reg) > maxd_reg) maxd_reg <= 10'(dist_reg);
                                state_reg <= S_OUT;
                            end
                        end else if (rd_st_reg == ST_EMPTY || dist_reg + LW'(1) >= size_reg)
                            state_reg <= (func_reg == FUNC_DELETE) ? S_DEL_SHR : S_OUT;
                        else begin
                            pos_reg <= pos_inc; dist_reg <= dist_reg + LW'(1);
                            state_reg <= S_PRB_A;
                        end
                    end
                end
                S_DEL_SHR: begin
                    if (size_reg >= eff_min && live100 < shr_prod && live_reg < half_size) begin
                        new_size_reg <= half_size;
                        src_reg      <= R_DEL;
                        scan_reg     <= '0;
                        state_reg    <= S_RH_CLR;
                    end else state_reg <= S_OUT;
                end
                S_RH_CLR: begin
                    rst_mem[scan_reg[AW-1:0]] <= ST_EMPTY;
                    if (scan_reg == LW'(MAX_SLOTS - 1)) begin
                        scan_reg  <= '0;
                        state_reg <= S_RH_SCAN_A;
                    end else scan_reg <= scan_reg + LW'(1);
                end
                S_RH_SCAN_A: begin
                    if (scan_reg >= size_reg) begin
                        scan_reg  <= '0;
                        state_reg <= S_RH_COPY_A;
                    end else begin
                        rd_st_reg  <= st_mem[scan_reg[AW-1:0]];
                        rd_key_reg <= key_mem[scan_reg[AW-1:0]];
                        state_reg  <= S_RH_SCAN_R;
                    end
                end
                S_RH_SCAN_R: begin
                    if (rd_st_reg == ST_LIVE) begin
                        mkey_reg  <= rd_key_reg;
                        rem_reg   <= '0;
                        div_m_reg <= new_size_reg;
                        bit_reg   <= KCW'(KEY_BITS);
                        state_reg <= S_RH_DIV;
                    end else begin
                        scan_reg  <= scan_reg + LW'(1);
                        state_reg <= S_RH_SCAN_A;
                    end
                end
                S_RH_DIV: begin
                    rem_reg  <= div_try[LW] ? {rem_reg[LW-2:0], mkey_reg[KEY_BITS-1]}
                                            : div_try[LW-1:0];
                    mkey_reg <= mkey_reg << 1;
                    bit_reg  <= bit_reg - KCW'(1);
                    if (bit_reg == KCW'(1)) begin
                        state_reg <= S_RH_PA;
                        pos_reg   <= div_try[LW] ? {rem_reg[LW-2:0], mkey_reg[KEY_BITS-1]}
                                                 : div_try[LW-1:0];
                        dist_reg  <= '0;
                    end
                end
                S_RH_PA: begin
                    rrd_st_reg <= rst_mem[pos_reg[AW-1:0]];
                    state_reg  <= S_RH_PR;
                end
                S_RH_PR: begin
                    if (rrd_st_reg == ST_EMPTY) begin
                        rst_mem[pos_reg[AW-1:0]]  <= ST_LIVE;
                        rkey_mem[pos_reg[AW-1:0]] <= rd_key_reg;
                        scan_reg  <= scan_reg + LW'(1);
                        state_reg <= S_RH_SCAN_A;
                    end else if (dist_reg + LW'(1) >= new_size_reg) begin
                        scan_reg  <= scan_reg + LW'(1);
                        state_reg <= S_RH_SCAN_A;
                    end else begin
                        pos_reg <= pos_inc; dist_reg <= dist_reg + LW'(1);
                        state_reg <= S_RH_PA;
                    end
                end
                S_RH_COPY_A: begin
                    rrd_st_reg  <= rst_mem[scan_reg[AW-1:0]];
                    rrd_key_reg <= rkey_mem[scan_reg[AW-1:0]];
                    state_reg   <= S_RH_COPY_W;
                end
                S_RH_COPY_W: begin
                    st_mem[scan_reg[AW-1:0]]  <= rrd_st_reg;
                    key_mem[scan_reg[AW-1:0]] <= rrd_key_reg;
                    if (scan_reg == LW'(MAX_SLOTS - 1)) begin
                        size_reg <= new_size_reg;
                        occ_reg  <= live_reg;
                        if (src_reg == R_INS) begin
                            mkey_reg   <= key_reg;
                            rem_reg    <= '0;
                            div_m_reg  <= new_size_reg;
                            bit_reg    <= KCW'(KEY_BITS);
                            res_st_reg <= RES_FULL;
                            state_reg  <= S_DIV;
                        end else state_reg <= S_OUT;
                    end else begin
                        scan_reg  <= scan_reg + LW'(1);
                        state_reg <= S_RH_COPY_A;
                    end
                end
                S_OUT: begin
                    out_v_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `LPHT_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, s_tready, state_reg == S_IDLE)
    `LPHT_ASSERT_NEXT(a_out_after_done, aclk, aresetn, state_reg == S_OUT, m_tvalid)
    `LPHT_ASSERT_IMP(a_live_le_occ, aclk, aresetn, state_reg == S_IDLE, live_reg <= occ_reg)
endmodule

// ===== dv/linear_probe_hash_table_test.sv =====
// Self-checking bench for the linear probing hash table: streams insert, delete and
// lookup operations and compares every answer with an in-bench table model.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
`timescale 1ns / 1ps
module linear_probe_hash_table_test;
    import lpht_pkg::*;

    localparam int SLOTS = 1024;
    localparam int KEYW  = 29;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000000;

    typedef struct packed {
        logic [1:0]      func;
        logic [KEYW-1:0] key;
    } hash_op_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] slot;
        logic [9:0] distance;
        logic [9:0] max_distance;
    } hash_answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // func[1:0], key[30:2], zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // status[1:0], slot[11:2], distance[21:12], max_distance[31:22]
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_MIN_SIZE;
    logic [10:0] cfg_data = '0;

    linear_probe_hash_table i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mirror of the block's table, configuration and counters.
    logic [KEYW-1:0] tbl_key [SLOTS];
    logic [1:0]      tbl_st  [SLOTS];
    logic [KEYW-1:0] scratch_key [SLOTS];
    logic [1:0]      scratch_st  [SLOTS];
    int unsigned tbl_size, occupied, live, max_hit_dist;
    int unsigned min_size_reg, shrink_reg, grow_reg;

    hash_op_t     pending_ops[$];
    hash_answer_t expected_answers[$];
    logic [KEYW-1:0] key_pool [32];

    int  send_idle_pct, recv_idle_pct;
    bit  hold_sender;
    bit  op_taken;
    int  errors = 0;
    int  quiet_cycles = 0;

    function automatic int unsigned clamped_min();
        if (min_size_reg < 1) return 1;
        if (min_size_reg > SLOTS) return SLOTS;
        return min_size_reg;
    endfunction

    // Move every live key, in slot order, into a fresh table of the new size.
    function automatic void rebuild_table(int unsigned new_size);
        int unsigned home, p;
        for (int i = 0; i < SLOTS; i++) scratch_st[i] = ST_EMPTY;
        for (int unsigned i = 0; i < tbl_size; i++) begin
            if (tbl_st[i] != ST_LIVE) continue;
            home = tbl_key[i] % new_size;
            for (int unsigned d = 0; d < new_size; d++) begin
                p = (home + d >= new_size) ? home + d - new_size : home + d;
                if (scratch_st[p] == ST_EMPTY) begin
                    scratch_st[p] = ST_LIVE;
                    scratch_key[p] = tbl_key[i];
                    break;
                end
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            tbl_st[i] = scratch_st[i];
            tbl_key[i] = scratch_key[i];
        end
        tbl_size = new_size;
        occupied = live;
    endfunction

    // Lookup walk: skips tombstones, stops at a never-used slot.
    function automatic bit find_key(logic [KEYW-1:0] key, output int unsigned pos,
                                    output int unsigned probe_dist);
        int unsigned home, p;
        home = key % tbl_size;
        pos = 0;
        probe_dist = 0;
        for (int unsigned d = 0; d < tbl_size; d++) begin
            p = (home + d >= tbl_size) ? home + d - tbl_size : home + d;
            if (tbl_st[p] == ST_EMPTY) return 1'b0;
            if (tbl_st[p] == ST_LIVE && tbl_key[p] == key) begin
                pos = p;
                probe_dist = d;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic hash_answer_t apply_hash_op(hash_op_t op);
        hash_answer_t a;
        int unsigned pos, hit_dist, home, p, ns, m;
        a = '0;
        a.status = RES_NOTFOUND;
        case (op.func)
            FUNC_INSERT: begin
                if (100 * occupied > grow_reg * tbl_size) begin
                    ns = (tbl_size * 2 > SLOTS) ? SLOTS : tbl_size * 2;
                    rebuild_table(ns);
                end
                a.status = RES_FULL;
                home = op.key % tbl_size;
                for (int unsigned d = 0; d < tbl_size; d++) begin
                    p = (home + d >= tbl_size) ? home + d - tbl_size : home + d;
                    if (tbl_st[p] == ST_EMPTY) begin
                        tbl_st[p] = ST_LIVE;
                        tbl_key[p] = op.key;
                        occupied++;
                        live++;
                        a.status = RES_OK;
                        a.slot = 10'(p);
                        a.distance = 10'(d);
                        break;
                    end
                end
            end
            FUNC_DELETE: begin
                if (find_key(op.key, pos, hit_dist)) begin
                    tbl_st[pos] = ST_TOMB;
                    if (live > 0) live--;
                    a.status = RES_OK;
                    a.slot = 10'(pos);
                    a.distance = 10'(hit_dist);
                end
                // Shrinking is considered after every delete, hit or miss.
                m = clamped_min();
                if (tbl_size >= m && 100 * live < tbl_size * shrink_reg) begin
                    ns = tbl_size / 2;
                    if (ns < m) ns = m;
                    if (live < ns) rebuild_table(ns);
                end
            end
            FUNC_LOOKUP: begin
                if (find_key(op.key, pos, hit_dist)) begin
                    a.status = RES_OK;
                    a.slot = 10'(pos);
                    a.distance = 10'(hit_dist);
                    if (hit_dist > max_hit_dist) max_hit_dist = hit_dist;
                end
            end
            default: ;
        endcase
        a.max_distance = 10'(max_hit_dist);
        return a;
    endfunction

    // Input side: the predictor runs on each accepted transaction.
    always @(posedge aclk) begin
        op_taken = aresetn && s_tvalid && s_tready;
        if (op_taken)
            expected_answers.push_back(apply_hash_op(hash_op_t'({s_tdata[1:0], s_tdata[30:2]})));
    end

    // Driver: a new transaction is only presented once the previous one was taken,
    // so tvalid never drops while an item is waiting.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || op_taken) begin
            if (pending_ops.size() > 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
                s_tdata <= {1'b0, pending_ops[0].key, pending_ops[0].func};
                s_tvalid <= 1'b1;
                void'(pending_ops.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: each answer is checked field by field against the oldest prediction.
    always @(posedge aclk) begin
        hash_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_answers.size() == 0) begin
                $error("unexpected answer %h", m_tdata);
                errors++;
            end else begin
                want = expected_answers.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[11:2] !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_tdata[11:2]);
                    errors++;
                end
                if (m_tdata[21:12] !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, m_tdata[21:12]);
                    errors++;
                end
                if (m_tdata[31:22] !== want.max_distance) begin
                    $error("max_distance: expected %0d, got %0d", want.max_distance,
                           m_tdata[31:22]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction on either side. The limit covers
    // the clearing pass after reset and the longest rehash this stimulus can cause.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_op(logic [1:0] func, logic [KEYW-1:0] key);
        pending_ops.push_back('{func: func, key: key});
    endtask

    task automatic wait_idle();
        while (pending_ops.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_MIN_SIZE: min_size_reg = value;
            CFG_SHRINK:   shrink_reg = value[6:0];
            CFG_GROW:     grow_reg = value[6:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int unsigned min_sz, int unsigned shrink, int unsigned grow);
        write_reg(CFG_MIN_SIZE, 11'(min_sz));
        write_reg(CFG_SHRINK, 11'(shrink));
        write_reg(CFG_GROW, 11'(grow));
    endtask

    // Mostly keys from a small pool so that deletes and lookups hit and homes collide;
    // the rest are full-width random keys. pool_span narrows the pool for crowding.
    task automatic queue_random_ops(int count, int pool_span);
        logic [1:0]      func;
        logic [KEYW-1:0] key;
        int r;
        for (int i = 0; i < 32; i++) key_pool[i] = KEYW'($urandom());
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            func = (r < 45) ? FUNC_INSERT : (r < 70) ? FUNC_DELETE :
                   (r < 96) ? FUNC_LOOKUP : FUNC_UNUSED;
            if ($urandom_range(99) < 75) key = key_pool[$urandom_range(pool_span - 1)];
            else key = KEYW'($urandom());
            queue_op(func, key);
        end
    endtask

    initial begin
        hold_sender = 1'b0;
        send_idle_pct = 15;
        recv_idle_pct = 58;
        min_size_reg = MIN_SIZE_RST;
        shrink_reg = SHRINK_RST;
        grow_reg = GROW_RST;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_st[i] = ST_EMPTY;
            tbl_key[i] = '0;
        end
        tbl_size = clamped_min();
        occupied = 0;
        live = 0;
        max_hit_dist = 0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: key extremes, every operation, unused selector, duplicates,
        // lookup across a tombstone, misses, and enough inserts to force growth.
        queue_op(FUNC_LOOKUP, '0);
        queue_op(FUNC_INSERT, '0);
        queue_op(FUNC_INSERT, '1);
        queue_op(FUNC_INSERT, 29'd16);
        queue_op(FUNC_INSERT, 29'd32);
        queue_op(FUNC_INSERT, 29'd16);
        queue_op(FUNC_LOOKUP, 29'd32);
        queue_op(FUNC_DELETE, 29'd16);
        queue_op(FUNC_LOOKUP, 29'd32);
        queue_op(FUNC_LOOKUP, 29'd16);
        queue_op(FUNC_DELETE, 29'd12345);
        queue_op(FUNC_UNUSED, '1);
        queue_op(FUNC_LOOKUP, '1);
        queue_op(FUNC_DELETE, '1);
        for (int i = 0; i < 11; i++) queue_op(FUNC_INSERT, KEYW'(i * 16 + 3));
        queue_random_ops(450, 32);
        wait_idle();

        // Growth on every insert once anything is stored, up to the largest table;
        // at the top the rehash keeps the size and only sweeps tombstones.
        set_config(1, 0, 0);
        queue_random_ops(150, 32);

        // Sender pauses here until every outstanding answer has come back.
        while (pending_ops.size() > 100) @(posedge aclk);
        hold_sender = 1'b1;
        while (s_tvalid || expected_answers.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        hold_sender = 1'b0;
        wait_idle();

        // Largest minimum with both thresholds at full scale: no growth, and every
        // delete rehashes at the same size.
        set_config(1024, 100, 100);
        queue_random_ops(100, 32);
        wait_idle();

        // Tiny table that never grows: fills up and reports a full table.
        send_idle_pct = 58;
        recv_idle_pct = 15;
        set_config(4, 50, 100);
        queue_random_ops(400, 8);
        wait_idle();

        // Minimum of zero clamps to one; eager shrinking.
        set_config(0, 100, 50);
        queue_random_ops(400, 16);
        wait_idle();

        // Minimum beyond the largest table clamps to it.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(2047, 127, 127);
        queue_random_ops(60, 32);
        wait_idle();

        set_config(MIN_SIZE_RST, SHRINK_RST, GROW_RST);
        queue_random_ops(450, 32);
        wait_idle();

        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
